// ----- rtl/core/pdu_pkg.sv -----
// pdu_pkg: shared types, character codes and the hex digit decoder
// for the percent decoder with utf-8 grouping
// no dependencies
package pdu_pkg;

	// result queue depth, one slot per byte of the largest group
	localparam int QDEPTH = 4;
	localparam int CNT_W  = $clog2(QDEPTH + 1);

	// parser modes
	localparam logic [2:0] MODE_PLAIN = 3'd0;
	localparam logic [2:0] MODE_HIGH  = 3'd1;
	localparam logic [2:0] MODE_LOW   = 3'd2;
	localparam logic [2:0] MODE_PCT   = 3'd3;
	localparam logic [2:0] MODE_DROP  = 3'd4;

	// character codes
	localparam logic [7:0] CH_PCT = 8'h25;
	localparam logic [7:0] CH_0   = 8'h30;
	localparam logic [7:0] CH_9   = 8'h39;
	localparam logic [7:0] CH_UA  = 8'h41;
	localparam logic [7:0] CH_UF  = 8'h46;
	localparam logic [7:0] CH_LA  = 8'h61;
	localparam logic [7:0] CH_LF  = 8'h66;

	// one result item
	typedef struct packed {
		logic [7:0] data;
		logic       err;
		logic       last;
	} res_t;

	// all results caused by one input byte, in order from entry 0
	typedef struct packed {
		logic [CNT_W-1:0]         cnt;
		res_t [QDEPTH-1:0]        ent;
	} burst_t;

	// returns {digit ok, nibble}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c inside {[CH_0:CH_9]}) begin
			r = {1'b1, 4'(c - CH_0)};
		end else if (c inside {[CH_UA:CH_UF]}) begin
			r = {1'b1, 4'(c - CH_UA + 8'd10)};
		end else if (c inside {[CH_LA:CH_LF]}) begin
			r = {1'b1, 4'(c - CH_LA + 8'd10)};
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/percent_decoder_utf8_grouped_unit.sv -----
// percent_decoder_utf8_grouped_unit: uri percent decoder that emits utf-8 groups whole
// path: a byte is registered at its transfer and decoded into the result queue once the queue
//   has room for its burst, so its first result is offered from the queue register
// throughput: one input byte per cycle; the four-entry queue drains one result per cycle when
//   out_stall is low; input waits only while the queue lacks room for the held byte's burst
// reset: arst_n clears stage valid, parser mode, nibble, group counters and the queue count
module percent_decoder_utf8_grouped_unit (
	input  logic       clk,
	input  logic       arst_n,
	// input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	// result channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_error,
	output logic       out_last
);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// decode and queue handshake
	pdu_pkg::burst_t           burst;
	logic [pdu_pkg::CNT_W-1:0] free;
	logic                      step;
	logic                      load;

	// the held byte goes through when the queue has room for everything it causes
	assign step     = valid_s1 & (burst.cnt <= free);
	assign in_stall = valid_s1 & ~step;
	assign load     = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// payload of the input stage, loaded on each input transfer
	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	// escape parser: mode, high nibble, group store and the results of one byte
	pdu_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_s1 (byte_s1),
		.last_s1 (last_s1),
		.step    (step),
		.burst   (burst)
	);

	// result queue, drained one transfer per cycle while out_stall is low
	pdu_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step),
		.burst     (burst),
		.free      (free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_error (out_error),
		.out_last  (out_last)
	);

	// a stalled input stage must hold a byte
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty stage");

endmodule

// ----- rtl/core/pdu_parse.sv -----
// pdu_parse: escape parser state and the next-state / result logic
// for one byte; uses pdu_pkg
module pdu_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          byte_s1,
	input  logic                last_s1,
	input  logic                step,
	output pdu_pkg::burst_t     burst
);

	logic [2:0] mode_q, mode_d;
	logic [3:0] hi_q, hi_d;
	logic [1:0] fill_q, fill_d;
	logic [1:0] togo_q, togo_d;
	logic [7:0] grp_q [3];
	logic [7:0] grp_d [3];

	logic [4:0] hexr;
	logic       hex_ok;
	logic [7:0] val;
	logic [2:0] cont;
	logic       fail;

	assign hexr   = pdu_pkg::hex_decode(byte_s1);
	assign hex_ok = hexr[4];
	assign val    = {hi_q, hexr[3:0]};

	// continuation count of a lead byte: run of ones below bit 7
	always_comb begin
		cont = 3'd0;
		if (val[7]) begin
			if (!val[6])      cont = 3'd0;
			else if (!val[5]) cont = 3'd1;
			else if (!val[4]) cont = 3'd2;
			else if (!val[3]) cont = 3'd3;
			else              cont = 3'd4;
		end
	end

	always_comb begin
		mode_d = mode_q;
		hi_d   = hi_q;
		fill_d = fill_q;
		togo_d = togo_q;
		for (int k = 0; k < 3; k++) begin
			grp_d[k] = grp_q[k];
		end
		burst  = '0;
		fail   = 1'b0;
		case (mode_q)
			pdu_pkg::MODE_DROP: begin
				if (last_s1) mode_d = pdu_pkg::MODE_PLAIN;
			end
			pdu_pkg::MODE_HIGH: begin
				if (!hex_ok) begin
					fail = 1'b1;
				end else begin
					hi_d   = hexr[3:0];
					mode_d = pdu_pkg::MODE_LOW;
					fail   = last_s1;
				end
			end
			pdu_pkg::MODE_LOW: begin
				if (!hex_ok) begin
					fail = 1'b1;
				end else if (fill_q == 2'd0) begin
					if (cont == 3'd4) begin
						fail = 1'b1;
					end else if (cont == 3'd0) begin
						burst.cnt    = pdu_pkg::CNT_W'(1);
						burst.ent[0] = '{data: val, err: 1'b0, last: last_s1};
						mode_d       = pdu_pkg::MODE_PLAIN;
					end else begin
						grp_d[0] = val;
						fill_d   = 2'd1;
						togo_d   = cont[1:0];
						mode_d   = pdu_pkg::MODE_PCT;
						fail     = last_s1;
					end
				end else if (togo_q <= 2'd1) begin
					// group complete: stored bytes then this one
					for (int k = 0; k < pdu_pkg::QDEPTH; k++) begin
						if (k < 3 && 2'(k) < fill_q) begin
							burst.ent[k] = '{data: grp_q[k], err: 1'b0, last: 1'b0};
						end else if (3'(k) == {1'b0, fill_q}) begin
							burst.ent[k] = '{data: val, err: 1'b0, last: last_s1};
						end
					end
					burst.cnt = pdu_pkg::CNT_W'(fill_q) + pdu_pkg::CNT_W'(1);
					fill_d    = 2'd0;
					togo_d    = 2'd0;
					mode_d    = pdu_pkg::MODE_PLAIN;
				end else begin
					for (int k = 0; k < 3; k++) begin
						if (2'(k) == fill_q) grp_d[k] = val;
					end
					fill_d = fill_q + 2'd1;
					togo_d = togo_q - 2'd1;
					mode_d = pdu_pkg::MODE_PCT;
					fail   = last_s1;
				end
			end
			pdu_pkg::MODE_PCT: begin
				if (byte_s1 != pdu_pkg::CH_PCT) begin
					fail = 1'b1;
				end else begin
					mode_d = pdu_pkg::MODE_HIGH;
					fail   = last_s1;
				end
			end
			default: begin
				if (byte_s1 != pdu_pkg::CH_PCT) begin
					burst.cnt    = pdu_pkg::CNT_W'(1);
					burst.ent[0] = '{data: byte_s1, err: 1'b0, last: last_s1};
					mode_d       = pdu_pkg::MODE_PLAIN;
				end else begin
					fill_d = 2'd0;
					togo_d = 2'd0;
					mode_d = pdu_pkg::MODE_HIGH;
					fail   = last_s1;
				end
			end
		endcase
		if (fail) begin
			burst        = '0;
			burst.cnt    = pdu_pkg::CNT_W'(1);
			burst.ent[0] = '{data: 8'd0, err: 1'b1, last: 1'b1};
			fill_d       = 2'd0;
			togo_d       = 2'd0;
			hi_d         = 4'd0;
			mode_d       = last_s1 ? pdu_pkg::MODE_PLAIN : pdu_pkg::MODE_DROP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pdu_pkg::MODE_PLAIN;
			hi_q   <= 4'd0;
			fill_q <= 2'd0;
			togo_q <= 2'd0;
		end else if (step) begin
			mode_q <= mode_d;
			hi_q   <= hi_d;
			fill_q <= fill_d;
			togo_q <= togo_d;
		end
	end

	// group bytes: no reset, always written before read within a group
	always_ff @(posedge clk) begin
		if (step) begin
			for (int k = 0; k < 3; k++) begin
				grp_q[k] <= grp_d[k];
			end
		end
	end

	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q <= pdu_pkg::MODE_DROP)
		else $error("parser mode out of range");

	a_err_alone: assert property (@(posedge clk) disable iff (!arst_n)
		step && burst.ent[0].err |-> burst.cnt == pdu_pkg::CNT_W'(1) && mode_d != mode_q ||
		step && burst.ent[0].err && mode_q == pdu_pkg::MODE_PLAIN)
		else $error("error result not alone or mode unchanged");

endmodule

// ----- rtl/core/pdu_outq.sv -----
// pdu_outq: result queue that takes a burst of up to four results
// and hands them out one transfer at a time; uses pdu_pkg
module pdu_outq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  pdu_pkg::burst_t               burst,
	output logic [pdu_pkg::CNT_W-1:0]     free,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    out_byte,
	output logic                          out_error,
	output logic                          out_last
);

	logic [pdu_pkg::CNT_W-1:0] cnt_q, cnt_d, base;
	pdu_pkg::res_t             lane_q [pdu_pkg::QDEPTH];
	pdu_pkg::res_t             lane_d [pdu_pkg::QDEPTH];
	logic                      pop;
	logic [pdu_pkg::CNT_W-1:0] off [pdu_pkg::QDEPTH];

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid & ~out_stall;
	assign base      = cnt_q - pdu_pkg::CNT_W'(pop);
	assign free      = pdu_pkg::CNT_W'(pdu_pkg::QDEPTH) - base;
	assign cnt_d     = base + (push ? burst.cnt : '0);

	always_comb begin
		for (int j = 0; j < pdu_pkg::QDEPTH; j++) begin
			if (pop && j < pdu_pkg::QDEPTH - 1) begin
				lane_d[j] = lane_q[j + 1];
			end else begin
				lane_d[j] = lane_q[j];
			end
			off[j] = pdu_pkg::CNT_W'(j) - base;
			if (push && pdu_pkg::CNT_W'(j) >= base && off[j] < burst.cnt) begin
				lane_d[j] = burst.ent[off[j][$clog2(pdu_pkg::QDEPTH)-1:0]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < pdu_pkg::QDEPTH; j++) begin
			lane_q[j] <= lane_d[j];
		end
	end

	assign out_byte  = lane_q[0].data;
	assign out_error = lane_q[0].err;
	assign out_last  = lane_q[0].last;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= pdu_pkg::CNT_W'(pdu_pkg::QDEPTH))
		else $error("result queue count above depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> burst.cnt <= free)
		else $error("burst pushed without room");

endmodule
